/* src/crdg_pkg.sv */
// Shared types, widths and constants of the circle ROI defect grader.
package crdg_pkg;

  // Default frame limits handed to the top-level parameters
  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  // Field and register widths
  localparam int unsigned GRAY_W     = 8;
  localparam int unsigned CX_W       = 12;
  localparam int unsigned CY_W       = 12;
  localparam int unsigned RAD_W      = 13;
  localparam int unsigned THR_W      = 8;
  localparam int unsigned LIM_W      = 17;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned CNT_W      = 25;
  localparam int unsigned VERD_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 56;

  // Q1.16 fixed point
  localparam int unsigned Q16_SH  = 16;
  localparam int unsigned ONE_Q16 = 65536;

  // Register reset values
  localparam int unsigned THR_RESET    = 100;
  localparam int unsigned LIM_RESET    = 13107;
  localparam int unsigned WIDTH_RESET  = 640;
  localparam int unsigned HEIGHT_RESET = 480;

  typedef enum logic [VERD_W-1:0] {
    VERDICT_ABNORMAL    = 2'd0,
    VERDICT_QUALIFIED   = 2'd1,
    VERDICT_UNQUALIFIED = 2'd2
  } verdict_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X        = 3'd0,
    CFG_CENTER_Y        = 3'd1,
    CFG_CIRCLE_RADIUS   = 3'd2,
    CFG_PIXEL_THRESHOLD = 3'd3,
    CFG_DEFECT_LIMIT    = 3'd4,
    CFG_IMAGE_WIDTH     = 3'd5,
    CFG_IMAGE_HEIGHT    = 3'd6
  } cfg_index_e;

  // Raster position status of the pixel at the head of the stream
  typedef struct packed {
    logic row_end;
    logic frame_end;
  } pix_flags_t;

endpackage

/* src/crdg_pos_track.sv */
// Raster position tracker: column and row of the next pixel, row and frame end.
module crdg_pos_track #(
  parameter int unsigned MAX_WIDTH  = crdg_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = crdg_pkg::MAX_HEIGHT_DEF,
  localparam int unsigned CW = $clog2(MAX_WIDTH),
  localparam int unsigned RW = $clog2(MAX_HEIGHT),
  localparam int unsigned PW = CW + 1,
  localparam int unsigned PH = RW + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [crdg_pkg::DIM_W-1:0]  image_width_i,
  input  logic [crdg_pkg::DIM_W-1:0]  image_height_i,
  output logic [CW-1:0]               col_o,
  output logic [RW-1:0]               row_o,
  output logic [PW-1:0]               width_o,
  output crdg_pkg::pix_flags_t        flags_o
);

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [PW-1:0] w;
  logic [PH-1:0] h;

  // Clamp the frame size to 1 .. maximum
  always_comb begin
    if (image_width_i == '0) begin
      w = PW'(1);
    end else if (32'(image_width_i) > MAX_WIDTH) begin
      w = PW'(MAX_WIDTH);
    end else begin
      w = PW'(image_width_i);
    end
    if (image_height_i == '0) begin
      h = PH'(1);
    end else if (32'(image_height_i) > MAX_HEIGHT) begin
      h = PH'(MAX_HEIGHT);
    end else begin
      h = PH'(image_height_i);
    end
  end

  // Detect the last column and the last pixel of the frame
  always_comb begin
    flags_o.row_end   = (PW'(col_q) + PW'(1)) >= w;
    flags_o.frame_end = flags_o.row_end && ((PH'(row_q) + PH'(1)) >= h);
  end

  // Advance the position on every accepted pixel
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (step_i) begin
      if (flags_o.frame_end) begin
        col_d = '0;
        row_d = '0;
      end else if (flags_o.row_end) begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o   = col_q;
  assign row_o   = row_q;
  assign width_o = w;

endmodule

/* src/circle_roi_defect_grader_unit.sv */
// Top level of the circle ROI defect grader: pixel pipeline, frame counters and verdict.
//
// Grey pixels enter in raster order on the slave stream, one per clock unless stalled; the
// block tracks the column and row from the configured frame size. Each pixel goes through a
// five-stage pipeline (position, squared distance, inside/good count, defect product,
// verdict), so a frame's verdict reaches the master stream through the stage registers
// and the output register. Input is taken every cycle while the output register is free or
// being drained; it pauses only when a second frame's result reaches the product stage
// before the first verdict has been taken. The user must write registers through the plain
// write port only while no pixel or frame result is in flight; the block does not enforce it.
module circle_roi_defect_grader_unit #(
  parameter int unsigned MAX_WIDTH  = crdg_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = crdg_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic [crdg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [crdg_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // Pixel stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [crdg_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // [7:0] gray_level
  // Result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [1:0] verdict, [26:2] inside_total, [51:27] good_total, [55:52] zero
  output logic [crdg_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  localparam int unsigned CW     = $clog2(MAX_WIDTH);
  localparam int unsigned RW     = $clog2(MAX_HEIGHT);
  localparam int unsigned PW     = CW + 1;
  localparam int unsigned DXW    = (CW > crdg_pkg::CX_W) ? CW : crdg_pkg::CX_W;
  localparam int unsigned DYW    = (RW > crdg_pkg::CY_W) ? RW : crdg_pkg::CY_W;
  localparam int unsigned R2_W   = 2 * crdg_pkg::RAD_W;
  localparam int unsigned DS_W   = ((DXW > DYW) ? 2 * DXW : 2 * DYW) + 1;
  localparam int unsigned CMP_W  = (DS_W > R2_W) ? DS_W : R2_W;
  localparam int unsigned PROD_W = crdg_pkg::LIM_W + crdg_pkg::CNT_W;
  localparam int unsigned PAD_W  = crdg_pkg::OUT_DATA_W - crdg_pkg::VERD_W
                                   - 2 * crdg_pkg::CNT_W;

  // Configuration registers
  logic [crdg_pkg::CX_W-1:0]  center_x_q;
  logic [crdg_pkg::CY_W-1:0]  center_y_q;
  logic [crdg_pkg::RAD_W-1:0] radius_q;
  logic [crdg_pkg::THR_W-1:0] threshold_q;
  logic [crdg_pkg::LIM_W-1:0] limit_q;
  logic [crdg_pkg::DIM_W-1:0] width_q;
  logic [crdg_pkg::DIM_W-1:0] height_q;

  // Write the addressed register; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q  <= '0;
      center_y_q  <= '0;
      radius_q    <= '0;
      threshold_q <= crdg_pkg::THR_W'(crdg_pkg::THR_RESET);
      limit_q     <= crdg_pkg::LIM_W'(crdg_pkg::LIM_RESET);
      width_q     <= crdg_pkg::DIM_W'(crdg_pkg::WIDTH_RESET);
      height_q    <= crdg_pkg::DIM_W'(crdg_pkg::HEIGHT_RESET);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        crdg_pkg::CFG_CENTER_X:        center_x_q  <= cfg_wdata_i[crdg_pkg::CX_W-1:0];
        crdg_pkg::CFG_CENTER_Y:        center_y_q  <= cfg_wdata_i[crdg_pkg::CY_W-1:0];
        crdg_pkg::CFG_CIRCLE_RADIUS:   radius_q    <= cfg_wdata_i[crdg_pkg::RAD_W-1:0];
        crdg_pkg::CFG_PIXEL_THRESHOLD: threshold_q <= cfg_wdata_i[crdg_pkg::THR_W-1:0];
        crdg_pkg::CFG_DEFECT_LIMIT:    limit_q     <= cfg_wdata_i[crdg_pkg::LIM_W-1:0];
        crdg_pkg::CFG_IMAGE_WIDTH:     width_q     <= cfg_wdata_i[crdg_pkg::DIM_W-1:0];
        crdg_pkg::CFG_IMAGE_HEIGHT:    height_q    <= cfg_wdata_i[crdg_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: stall everything only when a result meets a blocked output
  logic adv;
  logic accept;
  logic v1_q, v2_q, res3_q, res4_q;

  assign adv           = !(res4_q && m_axis_tvalid && !m_axis_tready);
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  // Raster position of the incoming pixel
  logic [CW-1:0]        col;
  logic [RW-1:0]        row;
  logic [PW-1:0]        w_clamped;
  crdg_pkg::pix_flags_t flags;

  crdg_pos_track #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (accept),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .col_o          (col),
    .row_o          (row),
    .width_o        (w_clamped),
    .flags_o        (flags)
  );

  // Stage 1: registered pixel and position
  logic [CW-1:0]              col1_q;
  logic [RW-1:0]              row1_q;
  logic [crdg_pkg::GRAY_W-1:0] gray1_q;
  logic                       last1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      col1_q  <= col;
      row1_q  <= row;
      gray1_q <= s_axis_tdata[crdg_pkg::GRAY_W-1:0];
      last1_q <= flags.frame_end;
    end
  end

  // Stage 2: squared distances and brightness test
  logic [DXW-1:0]   dx;
  logic [DYW-1:0]   dy;
  logic [2*DXW-1:0] dx2_q;
  logic [2*DYW-1:0] dy2_q;
  logic [R2_W-1:0]  r2_q;
  logic             bright2_q;
  logic             last2_q;

  always_comb begin
    if (DXW'(col1_q) >= DXW'(center_x_q)) begin
      dx = DXW'(col1_q) - DXW'(center_x_q);
    end else begin
      dx = DXW'(center_x_q) - DXW'(col1_q);
    end
    if (DYW'(row1_q) >= DYW'(center_y_q)) begin
      dy = DYW'(row1_q) - DYW'(center_y_q);
    end else begin
      dy = DYW'(center_y_q) - DYW'(row1_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx2_q     <= (2*DXW)'(dx) * (2*DXW)'(dx);
      dy2_q     <= (2*DYW)'(dy) * (2*DYW)'(dy);
      r2_q      <= R2_W'(radius_q) * R2_W'(radius_q);
      bright2_q <= gray1_q > threshold_q;
      last2_q   <= last1_q;
    end
  end

  // Stage 3: frame counters; hand the totals on at the frame end and clear
  logic                      inside2;
  logic [crdg_pkg::CNT_W-1:0] inside_cnt_q, good_cnt_q;
  logic [crdg_pkg::CNT_W-1:0] inside_nxt, good_nxt;
  logic [crdg_pkg::CNT_W-1:0] ins3_q, good3_q;
  logic                      abn3_q;

  always_comb begin
    inside2    = (CMP_W'(dx2_q) + CMP_W'(dy2_q)) < CMP_W'(r2_q);
    inside_nxt = inside_cnt_q + crdg_pkg::CNT_W'(inside2);
    good_nxt   = good_cnt_q + crdg_pkg::CNT_W'(inside2 && bright2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_cnt_q <= '0;
      good_cnt_q   <= '0;
    end else if (adv && v2_q) begin
      if (last2_q) begin
        inside_cnt_q <= '0;
        good_cnt_q   <= '0;
      end else begin
        inside_cnt_q <= inside_nxt;
        good_cnt_q   <= good_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ins3_q  <= inside_nxt;
      good3_q <= good_nxt;
      abn3_q  <= 32'(radius_q) < 32'(w_clamped >> 2);
    end
  end

  // Stage 4: required good count scaled by the allowed good fraction
  logic [crdg_pkg::LIM_W-1:0] lim_sat;
  logic [crdg_pkg::LIM_W-1:0] keep_frac;
  logic [PROD_W-1:0]          rhs4_q;
  logic [crdg_pkg::CNT_W-1:0] ins4_q, good4_q;
  logic                       abn4_q;

  always_comb begin
    if (32'(limit_q) > crdg_pkg::ONE_Q16) begin
      lim_sat = crdg_pkg::LIM_W'(crdg_pkg::ONE_Q16);
    end else begin
      lim_sat = limit_q;
    end
    keep_frac = crdg_pkg::LIM_W'(crdg_pkg::ONE_Q16) - lim_sat;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rhs4_q  <= PROD_W'(keep_frac) * PROD_W'(ins3_q);
      ins4_q  <= ins3_q;
      good4_q <= good3_q;
      abn4_q  <= abn3_q;
    end
  end

  // Verdict
  logic [PROD_W-1:0]  lhs4;
  crdg_pkg::verdict_e verdict;

  always_comb begin
    lhs4 = PROD_W'(good4_q) << crdg_pkg::Q16_SH;
    if (abn4_q) begin
      verdict = crdg_pkg::VERDICT_ABNORMAL;
    end else if (ins4_q != '0 && lhs4 >= rhs4_q) begin
      verdict = crdg_pkg::VERDICT_QUALIFIED;
    end else begin
      verdict = crdg_pkg::VERDICT_UNQUALIFIED;
    end
  end

  // Valid bits of the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      res3_q <= 1'b0;
      res4_q <= 1'b0;
    end else if (adv) begin
      v1_q   <= s_axis_tvalid;
      v2_q   <= v1_q;
      res3_q <= v2_q && last2_q;
      res4_q <= res3_q;
    end
  end

  // Output register: load a finished verdict, hold it until taken
  crdg_pkg::verdict_e         out_verdict_q;
  logic [crdg_pkg::CNT_W-1:0] out_inside_q, out_good_q;
  logic                       out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && res4_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res4_q) begin
      out_verdict_q <= verdict;
      out_inside_q  <= ins4_q;
      out_good_q    <= good4_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_good_q, out_inside_q, out_verdict_q};

  // Frame counters start from zero after a frame end leaves the count stage
  a_cnt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v2_q && last2_q) |=> (inside_cnt_q == '0 && good_cnt_q == '0))
    else $error("frame counters not cleared after frame end");

  // A qualified verdict needs at least one inside pixel
  a_qual_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_verdict_q == crdg_pkg::VERDICT_QUALIFIED) |-> (out_inside_q != '0))
    else $error("qualified verdict with empty circle");

  // A waiting result is never overwritten by the next frame
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready && res4_q) |=> $stable(m_axis_tdata))
    else $error("pending verdict overwritten");

  // A result leaves the product stage only into a free or draining output
  a_res_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res4_q && out_valid_q && !m_axis_tready) |=> res4_q)
    else $error("result lost in product stage");

endmodule

/* tb/circle_roi_defect_grader_unit_tb.sv */
// Testbench for the circle ROI defect grader: frame stimulus, verdict prediction and result check.
`timescale 1ns / 1ps

module circle_roi_defect_grader_unit_tb;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned INSIDE_LSB   = crdg_pkg::VERD_W;
  localparam int unsigned GOOD_LSB     = crdg_pkg::VERD_W + crdg_pkg::CNT_W;
  localparam int unsigned PAD_LSB      = crdg_pkg::VERD_W + 2 * crdg_pkg::CNT_W;
  localparam int unsigned PAD_W        = crdg_pkg::OUT_DATA_W - PAD_LSB;
  localparam int unsigned UNIFORM_GRAY = 101;
  localparam int unsigned GRADE_IDX_W  = 6;
  localparam int unsigned GRADE_DEPTH  = 1 << GRADE_IDX_W;
  localparam logic [crdg_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  typedef struct {
    crdg_pkg::verdict_e         verdict;
    logic [crdg_pkg::CNT_W-1:0] inside_total;
    logic [crdg_pkg::CNT_W-1:0] good_total;
  } frame_grade_t;

  logic                             clk_i          = 1'b0;
  logic                             rst_ni         = 1'b0;
  logic                             cfg_we_i       = 1'b0;
  logic [crdg_pkg::CFG_IDX_W-1:0]   cfg_index_i    = '0;
  logic [crdg_pkg::CFG_DATA_W-1:0]  cfg_wdata_i    = '0;
  logic                             s_axis_tvalid  = 1'b0;
  logic                             s_axis_tready;
  logic [crdg_pkg::IN_DATA_W-1:0]   s_axis_tdata   = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready  = 1'b0;
  logic [crdg_pkg::OUT_DATA_W-1:0]  m_axis_tdata;

  // Grader state mirrored by the predictor
  int unsigned center_x, center_y, circle_radius, pixel_threshold;
  int unsigned defect_limit, image_width, image_height;
  int unsigned column_pos, row_pos, inside_cnt, good_cnt;

  // Predicted grades in frame order, written by the sender and read by the checker
  frame_grade_t grade_fifo [GRADE_DEPTH];
  int unsigned  grade_wr_cnt = 0;
  int unsigned  grade_rd_cnt = 0;

  int unsigned  src_idle_pct;
  int unsigned  sink_idle_pct;
  int unsigned  pixels_sent;
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;

  circle_roi_defect_grader_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stall the result stream at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  // Compare each accepted result with the oldest predicted grade
  always @(negedge clk_i) begin : check_results
    frame_grade_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (grade_wr_cnt == grade_rd_cnt) begin
        report_mismatch("result with no frame pending", m_axis_tdata, 0);
      end else begin
        want = grade_fifo[GRADE_IDX_W'(grade_rd_cnt)];
        grade_rd_cnt++;
        if (m_axis_tdata[crdg_pkg::VERD_W-1:0] !== want.verdict)
          report_mismatch("verdict", m_axis_tdata[crdg_pkg::VERD_W-1:0], want.verdict);
        if (m_axis_tdata[INSIDE_LSB +: crdg_pkg::CNT_W] !== want.inside_total)
          report_mismatch("inside_total", m_axis_tdata[INSIDE_LSB +: crdg_pkg::CNT_W],
                          want.inside_total);
        if (m_axis_tdata[GOOD_LSB +: crdg_pkg::CNT_W] !== want.good_total)
          report_mismatch("good_total", m_axis_tdata[GOOD_LSB +: crdg_pkg::CNT_W],
                          want.good_total);
        if (m_axis_tdata[PAD_LSB +: PAD_W] !== '0)
          report_mismatch("padding", m_axis_tdata[PAD_LSB +: PAD_W], 0);
      end
    end
  end

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  // Advance the raster position and counts for one accepted pixel
  task automatic grade_pixel(input logic [crdg_pkg::GRAY_W-1:0] gray);
    int unsigned     w, h, lim;
    longint unsigned dx, dy, r2, lhs, rhs;
    logic            row_end, frame_end;
    frame_grade_t    g;
    w  = clamp_dim(image_width, crdg_pkg::MAX_WIDTH_DEF);
    h  = clamp_dim(image_height, crdg_pkg::MAX_HEIGHT_DEF);
    r2 = longint'(circle_radius) * circle_radius;
    dx = (column_pos >= center_x) ? column_pos - center_x : center_x - column_pos;
    dy = (row_pos >= center_y) ? row_pos - center_y : center_y - row_pos;
    if (dx * dx + dy * dy < r2) begin
      inside_cnt = (inside_cnt + 1) & ((1 << crdg_pkg::CNT_W) - 1);
      if (gray > pixel_threshold) good_cnt = (good_cnt + 1) & ((1 << crdg_pkg::CNT_W) - 1);
    end
    row_end   = (column_pos + 1 >= w);
    frame_end = row_end && (row_pos + 1 >= h);
    if (!frame_end) begin
      if (row_end) begin
        column_pos = 0;
        row_pos++;
      end else begin
        column_pos++;
      end
    end else begin
      lim = (defect_limit > crdg_pkg::ONE_Q16) ? crdg_pkg::ONE_Q16 : defect_limit;
      lhs = longint'(good_cnt) * crdg_pkg::ONE_Q16;
      rhs = longint'(crdg_pkg::ONE_Q16 - lim) * inside_cnt;
      if (circle_radius < w / 4) g.verdict = crdg_pkg::VERDICT_ABNORMAL;
      else if (inside_cnt != 0 && lhs >= rhs) g.verdict = crdg_pkg::VERDICT_QUALIFIED;
      else g.verdict = crdg_pkg::VERDICT_UNQUALIFIED;
      g.inside_total = crdg_pkg::CNT_W'(inside_cnt);
      g.good_total   = crdg_pkg::CNT_W'(good_cnt);
      grade_fifo[GRADE_IDX_W'(grade_wr_cnt)] = g;
      grade_wr_cnt++;
      column_pos = 0;
      row_pos    = 0;
      inside_cnt = 0;
      good_cnt   = 0;
    end
  endtask

  // Send one pixel request; called and returns just after a rising edge
  task automatic send_pixel(input logic [crdg_pkg::GRAY_W-1:0] gray);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= gray;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    grade_pixel(gray);
    pixels_sent++;
  endtask

  // Hold off until every grade has arrived and the pipeline has drained
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (grade_wr_cnt != grade_rd_cnt) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; only while the grader is idle
  task automatic write_reg(input logic [crdg_pkg::CFG_IDX_W-1:0] idx, input int unsigned value);
    logic [crdg_pkg::CFG_DATA_W-1:0] data;
    data = crdg_pkg::CFG_DATA_W'(value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      crdg_pkg::CFG_CENTER_X:        center_x        = 32'(data[crdg_pkg::CX_W-1:0]);
      crdg_pkg::CFG_CENTER_Y:        center_y        = 32'(data[crdg_pkg::CY_W-1:0]);
      crdg_pkg::CFG_CIRCLE_RADIUS:   circle_radius   = 32'(data[crdg_pkg::RAD_W-1:0]);
      crdg_pkg::CFG_PIXEL_THRESHOLD: pixel_threshold = 32'(data[crdg_pkg::THR_W-1:0]);
      crdg_pkg::CFG_DEFECT_LIMIT:    defect_limit    = 32'(data[crdg_pkg::LIM_W-1:0]);
      crdg_pkg::CFG_IMAGE_WIDTH:     image_width     = 32'(data[crdg_pkg::DIM_W-1:0]);
      crdg_pkg::CFG_IMAGE_HEIGHT:    image_height    = 32'(data[crdg_pkg::DIM_W-1:0]);
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Pick a grey level that is good with the given percentage, or uniform
  function automatic logic [crdg_pkg::GRAY_W-1:0] pick_gray(input int unsigned good_pct);
    if (good_pct >= UNIFORM_GRAY || pixel_threshold >= 255)
      return crdg_pkg::GRAY_W'($urandom_range(255));
    if ($urandom_range(99) < good_pct)
      return crdg_pkg::GRAY_W'($urandom_range(255, pixel_threshold + 1));
    return crdg_pkg::GRAY_W'($urandom_range(pixel_threshold, 0));
  endfunction

  // Send pixels until the raster position wraps back to the frame start
  task automatic send_rest_of_frame(input int unsigned good_pct);
    do send_pixel(pick_gray(good_pct));
    while (column_pos != 0 || row_pos != 0);
  endtask

  // Send a frame whose first n_bright pixels are bright and the rest dark
  task automatic send_pattern_frame(input int unsigned n_bright,
                                    input logic [crdg_pkg::GRAY_W-1:0] bright,
                                    input logic [crdg_pkg::GRAY_W-1:0] dark);
    int unsigned n;
    n = 0;
    do begin
      send_pixel((n < n_bright) ? bright : dark);
      n++;
    end while (column_pos != 0 || row_pos != 0);
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h, input int unsigned cx,
                              input int unsigned cy, input int unsigned rad);
    write_reg(crdg_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(crdg_pkg::CFG_IMAGE_HEIGHT, h);
    write_reg(crdg_pkg::CFG_CENTER_X, cx);
    write_reg(crdg_pkg::CFG_CENTER_Y, cy);
    write_reg(crdg_pkg::CFG_CIRCLE_RADIUS, rad);
  endtask

  // Reset values: height, radius, threshold and limit as they come out of reset
  task automatic test_reset_defaults();
    write_reg(crdg_pkg::CFG_IMAGE_WIDTH, 1);
    send_rest_of_frame(UNIFORM_GRAY);
    wait_idle();
    write_reg(crdg_pkg::CFG_IMAGE_HEIGHT, 20);
    write_reg(crdg_pkg::CFG_CENTER_Y, 10);
    write_reg(crdg_pkg::CFG_CIRCLE_RADIUS, 5);
    send_rest_of_frame(85);
    wait_idle();
  endtask

  // Zero and oversized dimensions, centre at the far corner, largest radius
  task automatic test_dimension_extremes();
    set_geometry(0, 0, 0, 0, 0);
    send_rest_of_frame(UNIFORM_GRAY);
    send_rest_of_frame(UNIFORM_GRAY);
    wait_idle();
    // widest row with the centre at the last column; narrow the row to end it
    set_geometry(4096, 1, 4095, 0, 4090);
    repeat (30) send_pixel(pick_gray(60));
    wait_idle();
    write_reg(crdg_pkg::CFG_IMAGE_WIDTH, 2);
    send_rest_of_frame(60);
    wait_idle();
    // saturated height and largest radius; shorten the frame to end it
    set_geometry(1, 8191, 0, 4095, 8191);
    write_reg(crdg_pkg::CFG_PIXEL_THRESHOLD, 0);
    repeat (30) send_pixel(pick_gray(UNIFORM_GRAY));
    wait_idle();
    write_reg(crdg_pkg::CFG_IMAGE_HEIGHT, 2);
    send_rest_of_frame(UNIFORM_GRAY);
    wait_idle();
    // saturated width; narrow the row to end it
    set_geometry(8191, 1, 0, 0, 0);
    repeat (40) send_pixel(pick_gray(UNIFORM_GRAY));
    wait_idle();
    write_reg(crdg_pkg::CFG_IMAGE_WIDTH, 3);
    send_rest_of_frame(UNIFORM_GRAY);
    wait_idle();
  endtask

  // Verdict boundaries, threshold edges, limit saturation, empty and small circles
  task automatic test_verdict_cases();
    // all 16 pixels inside; limit 0.25 needs 12 good pixels
    set_geometry(4, 4, 0, 0, 8);
    write_reg(crdg_pkg::CFG_PIXEL_THRESHOLD, 128);
    write_reg(crdg_pkg::CFG_DEFECT_LIMIT, 16384);
    send_pattern_frame(12, 200, 128);
    send_pattern_frame(11, 129, 128);
    wait_idle();
    // zero limit needs every pixel good
    write_reg(crdg_pkg::CFG_DEFECT_LIMIT, 0);
    send_pattern_frame(16, 255, 0);
    send_pattern_frame(15, 255, 0);
    wait_idle();
    // full and saturated limit pass; the full one even with no good pixel
    write_reg(crdg_pkg::CFG_DEFECT_LIMIT, crdg_pkg::ONE_Q16);
    write_reg(crdg_pkg::CFG_PIXEL_THRESHOLD, 255);
    send_pattern_frame(16, 255, 254);
    wait_idle();
    write_reg(crdg_pkg::CFG_DEFECT_LIMIT, 131071);
    write_reg(crdg_pkg::CFG_PIXEL_THRESHOLD, 0);
    send_pattern_frame(3, 1, 0);
    wait_idle();
    // no inside pixel and no small circle
    set_geometry(3, 2, 1, 1, 0);
    write_reg(crdg_pkg::CFG_DEFECT_LIMIT, 13107);
    send_rest_of_frame(UNIFORM_GRAY);
    wait_idle();
    // small circle wins over an empty one, then over a bright one
    set_geometry(4, 1, 0, 0, 0);
    send_rest_of_frame(UNIFORM_GRAY);
    wait_idle();
    set_geometry(8, 2, 0, 0, 1);
    send_pattern_frame(16, 255, 255);
    wait_idle();
  endtask

  // Shrink width and height while a frame is half done
  task automatic test_geometry_change_mid_frame();
    set_geometry(8, 4, 3, 1, 3);
    write_reg(crdg_pkg::CFG_PIXEL_THRESHOLD, 90);
    repeat (5) send_pixel(pick_gray(50));
    wait_idle();
    write_reg(crdg_pkg::CFG_IMAGE_WIDTH, 3);
    repeat (4) send_pixel(pick_gray(50));
    wait_idle();
    write_reg(crdg_pkg::CFG_IMAGE_HEIGHT, 2);
    send_rest_of_frame(50);
    wait_idle();
  endtask

  // A write to the unused index changes nothing
  task automatic test_unused_index();
    set_geometry(5, 3, 2, 1, 2);
    write_reg(CFG_UNUSED_IDX, 131071);
    send_rest_of_frame(70);
    wait_idle();
    write_reg(CFG_UNUSED_IDX, 0);
    send_rest_of_frame(70);
    wait_idle();
  endtask

  // Choose a new small frame setup, sometimes with wide-ranging values
  task automatic randomize_setup();
    int unsigned w, h;
    w = ($urandom_range(29) == 0) ? $urandom_range(64, 1) : $urandom_range(12, 1);
    h = ($urandom_range(29) == 0) ? $urandom_range(32, 1) : $urandom_range(8, 1);
    if ($urandom_range(19) == 0) w = 0;
    if ($urandom_range(19) == 0) h = 0;
    write_reg(crdg_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(crdg_pkg::CFG_IMAGE_HEIGHT, h);
    write_reg(crdg_pkg::CFG_CENTER_X,
              ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(w + 2));
    write_reg(crdg_pkg::CFG_CENTER_Y,
              ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(h + 2));
    write_reg(crdg_pkg::CFG_CIRCLE_RADIUS,
              ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(w + 4));
    if ($urandom_range(1) == 0) write_reg(crdg_pkg::CFG_PIXEL_THRESHOLD, $urandom_range(255));
    case ($urandom_range(4))
      0:       write_reg(crdg_pkg::CFG_DEFECT_LIMIT, $urandom_range(131071));
      1:       write_reg(crdg_pkg::CFG_DEFECT_LIMIT,
                         ($urandom_range(1) == 0) ? 0 : crdg_pkg::ONE_Q16);
      default: write_reg(crdg_pkg::CFG_DEFECT_LIMIT, $urandom_range(crdg_pkg::ONE_Q16));
    endcase
  endtask

  // Random frames under one idling pattern
  task automatic test_random_frames(input int unsigned src_pct, input int unsigned sink_pct,
                                    input int unsigned n_pixels);
    int unsigned stop_at, w, h, part;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    stop_at = pixels_sent + n_pixels;
    while (pixels_sent < stop_at) begin
      if ($urandom_range(99) < 60) begin
        wait_idle();
        randomize_setup();
      end
      w = clamp_dim(image_width, crdg_pkg::MAX_WIDTH_DEF);
      h = clamp_dim(image_height, crdg_pkg::MAX_HEIGHT_DEF);
      // now and then change the geometry partway through the frame
      if (w * h > 1 && $urandom_range(19) == 0) begin
        part = $urandom_range(w * h - 1, 1);
        repeat (part) send_pixel(pick_gray(50));
        wait_idle();
        write_reg(crdg_pkg::CFG_IMAGE_WIDTH, $urandom_range(12, 1));
        write_reg(crdg_pkg::CFG_IMAGE_HEIGHT, $urandom_range(8, 1));
      end
      send_rest_of_frame(($urandom_range(7) == 0) ? UNIFORM_GRAY : $urandom_range(100));
    end
    wait_idle();
  endtask

  initial begin
    center_x        = 0;
    center_y        = 0;
    circle_radius   = 0;
    pixel_threshold = crdg_pkg::THR_RESET;
    defect_limit    = crdg_pkg::LIM_RESET;
    image_width     = crdg_pkg::WIDTH_RESET;
    image_height    = crdg_pkg::HEIGHT_RESET;
    column_pos      = 0;
    row_pos         = 0;
    inside_cnt      = 0;
    good_cnt        = 0;
    src_idle_pct    = 18;
    sink_idle_pct   = 58;
    pixels_sent     = 0;

    // Hold reset at the start, then release it
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_dimension_extremes();
    test_verdict_cases();
    test_geometry_change_mid_frame();
    test_unused_index();
    test_random_frames(18, 58, 310);
    test_random_frames(58, 18, 310);
    test_random_frames(0, 0, 310);

    wait_idle();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
